[hdl/pfx_pkg.sv]
`timescale 1ns / 1ps
package pfx_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int CHAR_W      = 8;
   localparam int STAT_W      = 3;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
   localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd3;
   localparam logic [STAT_W-1:0] ST_BADCHAR   = 3'd4;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [STAT_W-1:0]        status;
   } rsp_payload_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic div_commit;
      logic emit;
   } ctl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic div_go;
      logic last;
      logic div_done;
      logic out_free;
   } dp_sts_type;

endpackage

[hdl/pfx_ram.sv]
`timescale 1ns / 1ps
module pfx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pfx_div.sv]
`timescale 1ns / 1ps
module pfx_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pfx_pkg::DATA_W-1:0]  dividend,
   input  logic [pfx_pkg::DATA_W-1:0]  divisor,
   output logic                        done,
   output logic [pfx_pkg::DATA_W-1:0]  quotient
);
   import pfx_pkg::*;

   localparam int STEP_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
         den_in  = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         rem_in  = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
         quo_in  = {quo_ff[DATA_W-2:0], ~diff[DATA_W]};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

endmodule

[hdl/pfx_datapath.sv]
`timescale 1ns / 1ps
module pfx_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  pfx_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pfx_pkg::rsp_payload_type rsp_payload,
   input  pfx_pkg::ctl_cmd_type     cmd,
   output pfx_pkg::dp_sts_type      sts
);
   import pfx_pkg::*;

   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic [DATA_W-1:0] tos_ff, tos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [STAT_W-1:0] error_ff, error_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]  cnt_m1;
   logic [CNT_W-1:0]  cnt_m2;
   logic              ram_we;
   logic [DATA_W-1:0] second;
   logic [DATA_W-1:0] quotient;
   logic              div_done;
   logic              div_go;
   logic              out_free;

   assign cnt_m1   = count_ff - CNT_W'(1);
   assign cnt_m2   = count_ff - CNT_W'(2);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // entries below the top of stack; the top lives in tos_ff
   pfx_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_m1[ADDR_W-1:0]),
      .wr_data (tos_ff),
      .rd_addr (cnt_m2[ADDR_W-1:0]),
      .rd_data (second)
   );

   pfx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.exec && div_go),
      .dividend (second),
      .divisor  (tos_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      char_in      = char_ff;
      last_in      = last_ff;
      tos_in       = tos_ff;
      count_in     = count_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      div_go       = 1'b0;

      if (cmd.capture) begin
         char_in = req_payload.char_code;
         last_in = req_payload.last_char;
      end

      if (cmd.exec && error_ff == ST_OK) begin
         case (char_ff) inside
            [CHAR_ZERO:CHAR_NINE]: begin
               if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                  error_in = ST_OVERFLOW;
               end else begin
                  ram_we   = (count_ff != '0);
                  tos_in   = {{(DATA_W-CHAR_W){1'b0}}, char_ff - CHAR_ZERO};
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH: begin
               if (count_ff < CNT_W'(2)) begin
                  error_in = ST_UNDERFLOW;
               end else if (char_ff == CHAR_SLASH) begin
                  if (tos_ff == '0) begin
                     error_in = ST_DIVZERO;
                  end else begin
                     div_go = 1'b1;
                  end
               end else begin
                  count_in = cnt_m1;
                  if (char_ff == CHAR_PLUS) begin
                     tos_in = second + tos_ff;
                  end else if (char_ff == CHAR_MINUS) begin
                     tos_in = second - tos_ff;
                  end else begin
                     tos_in = second * tos_ff;
                  end
               end
            end
            default: begin
               error_in = ST_BADCHAR;
            end
         endcase
      end

      if (cmd.div_commit) begin
         tos_in   = quotient;
         count_in = cnt_m1;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (error_ff != ST_OK) begin
            rsp_data_in.value  = '0;
            rsp_data_in.status = error_ff;
         end else if (count_ff == '0) begin
            rsp_data_in.value  = '0;
            rsp_data_in.status = ST_EMPTY;
         end else begin
            rsp_data_in.value  = tos_ff;
            rsp_data_in.status = ST_OK;
         end
         count_in = '0;
         error_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         error_ff     <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff     <= char_in;
      last_ff     <= last_in;
      tos_ff      <= tos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_data_ff;
   assign sts.div_go   = div_go;
   assign sts.last     = last_ff;
   assign sts.div_done = div_done;
   assign sts.out_free = out_free;

endmodule

[hdl/pfx_ctrl.sv]
`timescale 1ns / 1ps
module pfx_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pfx_pkg::dp_sts_type  sts,
   output pfx_pkg::ctl_cmd_type cmd
);
   import pfx_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.div_go) begin
               state_in = S_DIV;
            end else if (sts.last) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.div_commit = 1'b1;
               state_in       = sts.last ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

[hdl/postfix_expression_evaluator_unit.sv]
`timescale 1ns / 1ps
// Postfix evaluator for single-digit operands: one character per transaction on req_,
// with last_char marking the end of an expression. Digits push, + - * / pop two entries
// and push the 32-bit wrapped result (division truncates toward zero). After the last
// character one rsp_ transaction carries the top of stack and a status (0 ok, 1 underflow,
// 2 overflow, 3 divide by zero, 4 bad char, 5 empty; value is zero when status is not ok),
// and the stack and sticky error are cleared. One character is worked on at a time: after
// acceptance a digit, +, - or * passes the execute state before the next ready, a / also
// waits in the divide state for the bit-per-cycle divider, and a last character then passes
// the result-load state to load the result register, staying there only while a previous
// result there is still not taken. The top of stack sits in a register and the rest in a
// 64-entry RAM with one write and one read port; the RAM needs no clearing after reset.
module postfix_expression_evaluator_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pfx_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pfx_pkg::rsp_payload_type rsp_payload
);
   import pfx_pkg::*;

   // control handshake between sequencer and datapath
   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // sequencer: idle, execute, divide wait, result load
   pfx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stack, alu, divider and result register
   pfx_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
